// ----- src/jdc_pkg.sv -----
// Shared constants, types and calendar helpers for the Julian date converter.
// No dependencies; used by julian_day_to_calendar and its checker.
`default_nettype none

package jdc_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned DN_W   = 22;
  localparam int unsigned FR_W   = 32;
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned DAY_W  = 5;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned MS_W   = 10;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 56;

  // Richards' algorithm constants.
  localparam longint unsigned RICH_J   = 64'd1401;
  localparam longint unsigned RICH_OFS = 64'd38;
  localparam longint unsigned RICH_B   = 64'd274277;
  localparam longint unsigned RICH_C   = 64'd146097;
  localparam longint unsigned RICH_E   = 64'd1461;
  localparam longint unsigned RICH_Y   = 64'd4716;
  // Offset from the cycle count to the year plus 4800 for a January or February date.
  localparam longint unsigned YY_OFS   = 64'd85;

  // Internal widths.
  localparam int unsigned A_W   = 25;  // 4*jd + 274277
  localparam int unsigned Q1_W  = 7;   // century term, at most 116
  localparam int unsigned F_W   = 23;
  localparam int unsigned E_W   = 25;
  localparam int unsigned Y_W   = 14;  // 4-year cycle count, at most 11487
  localparam int unsigned G_W   = 9;   // day of March-based year, 0..365
  localparam int unsigned C_W   = 7;   // century of year plus 4800
  localparam int unsigned MUL_W = 26;
  localparam int unsigned CM_W  = 15;

  // Exact reciprocals: ceil(2^k / d) with 2^k at least the operand range times d.
  localparam int unsigned Q1_SH = 43;
  localparam logic [MUL_W-1:0] Q1_MUL =
    MUL_W'(((64'd1 << Q1_SH) + RICH_C - 64'd1) / RICH_C);
  localparam int unsigned Y_SH = 36;
  localparam logic [MUL_W-1:0] Y_MUL =
    MUL_W'(((64'd1 << Y_SH) + RICH_E - 64'd1) / RICH_E);
  localparam int unsigned C_SH = 21;
  localparam logic [CM_W-1:0] C_MUL =
    CM_W'(((64'd1 << C_SH) + 64'd100 - 64'd1) / 64'd100);

  typedef logic [YEAR_W-1:0] year_t;
  typedef logic [MON_W-1:0]  mon_t;
  typedef logic [DAY_W-1:0]  day_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [MS_W-1:0]   millisecond;
  } tod_t;

  // First day of each month in a year that starts on March 1 (index 0 is March).
  function automatic logic [G_W-1:0] month_start(input logic [3:0] idx);
    logic [G_W-1:0] s;
    case (idx)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // Length of a calendar month, 1 is January.
  function automatic day_t month_len(input mon_t mon, input logic leap);
    day_t d;
    case (mon)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- src/julian_day_to_calendar.sv -----
// An input transfer loads stage 1; the result moves stage by stage to the output.
// Throughput: one Julian date per cycle unless stalled; each stage advances when
// empty or when its successor advances, so bubbles are squeezed out in a stall.
// Reset (rst_n low, synchronous) clears every stage valid bit; payload is not reset.
// Julian date to Gregorian date and time of day, eight-stage pipeline; uses jdc_pkg.
`default_nettype none

module julian_day_to_calendar (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [21:0] day_number, [53:22] day_fraction, [55:54] zero
  input  logic [jdc_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [13:0] year, [17:14] month, [22:18] day_of_month, [27:23] hour,
  // [33:28] minute, [39:34] second, [49:40] millisecond, [55:50] zero
  output logic [jdc_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import jdc_pkg::*;

  localparam int unsigned NSTG = 8;

  // Stage valid bits and load enables. A stage loads when it holds nothing or
  // when the stage after it loads in the same cycle.
  logic [NSTG:1] v_r;
  logic [NSTG:1] ld;

  always_comb begin
    ld[NSTG] = ~v_r[NSTG] | out_tready;
    for (int i = NSTG - 1; i >= 1; i--) begin
      ld[i] = ~v_r[i] | ld[i+1];
    end
  end

  assign in_tready = ld[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[1]) begin
        v_r[1] <= in_tvalid;
      end
      for (int i = 2; i <= NSTG; i++) begin
        if (ld[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Input unpacking. Julian days start at noon, so the time since midnight is
  // the fraction plus one half day, which is the fraction with its top bit flipped.
  logic [DN_W-1:0] in_dn;
  logic [FR_W-1:0] in_fr;
  logic [FR_W-1:0] in_t;

  assign in_dn = in_tdata[DN_W-1:0];
  assign in_fr = in_tdata[DN_W+FR_W-1:DN_W];
  assign in_t  = {~in_fr[FR_W-1], in_fr[FR_W-2:0]};

  // The time of day is split one unit per stage: each stage multiplies the
  // remaining Q0.32 fraction by the unit ratio and keeps the integer part.
  tod_t            tod_r [1:NSTG-1];
  logic [FR_W-1:0] rem_r [1:3];
  logic            pm_r  [1:NSTG-1];

  logic [FR_W+4:0] p24;
  logic [FR_W+5:0] p60_m;
  logic [FR_W+5:0] p60_s;
  logic [FR_W+9:0] p1000;

  assign p24   = (FR_W+5)'(in_t) * (FR_W+5)'(24);
  assign p60_m = (FR_W+6)'(rem_r[1]) * (FR_W+6)'(60);
  assign p60_s = (FR_W+6)'(rem_r[2]) * (FR_W+6)'(60);
  assign p1000 = (FR_W+10)'(rem_r[3]) * (FR_W+10)'(1000);

  // Date path, Richards' algorithm. Divisions by constants are exact reciprocal
  // multiplications; remainders come from a multiply-back in the next stage.
  logic [DN_W-1:0]        s1_dn_r, s2_dn_r;
  logic [A_W-1:0]         s1_a_r;
  logic [Q1_W-1:0]        s2_q1_r;
  logic [E_W-1:0]         s3_e_r, s4_e_r;
  logic [Y_W-1:0]         s4_y_r, s5_y_r, s5_yy_r, s6_yy_r;
  logic [G_W-1:0]         s5_g_r;
  logic [C_W-1:0]         s6_c_r;
  year_t                  s6_year_r, s7_year_r;
  mon_t                   s6_mon_r, s7_mon_r;
  day_t                   s6_day_r, s7_day_r;
  logic                   s7_leap_r;

  logic [A_W+MUL_W-1:0]   q1_prod;
  logic [8:0]             q1x3;
  logic [F_W-1:0]         f_val;
  logic [E_W+MUL_W-1:0]   y_prod;
  logic [E_W-1:0]         y_back;
  logic [E_W-1:0]         e_rem;
  logic [Y_W+CM_W-1:0]    c_prod;
  logic [Y_W-1:0]         c_back;
  logic                   leap_nxt;

  assign q1_prod = (A_W+MUL_W)'(s1_a_r) * (A_W+MUL_W)'(Q1_MUL);
  assign q1x3    = {2'b00, s2_q1_r} + {1'b0, s2_q1_r, 1'b0};
  assign f_val   = F_W'(s2_dn_r) + F_W'(RICH_J - RICH_OFS) + F_W'(q1x3[8:2]);
  assign y_prod  = (E_W+MUL_W)'(s3_e_r) * (E_W+MUL_W)'(Y_MUL);
  assign y_back  = E_W'(s4_y_r) * E_W'(RICH_E);
  assign e_rem   = s4_e_r - y_back;
  assign c_prod  = (Y_W+CM_W)'(s5_yy_r) * (Y_W+CM_W)'(C_MUL);
  assign c_back  = Y_W'(s6_c_r) * Y_W'(100);

  // Leap rule on the year plus 4800, which has the same leap pattern as the
  // year: divisible by 4, and either not by 100 or also by 400.
  assign leap_nxt = (s6_yy_r[1:0] == 2'b00) &&
                    ((s6_yy_r != c_back) || (s6_c_r[1:0] == 2'b00));

  // Month lookup in the March-based year: the last month start not past g.
  logic [3:0]     midx;
  logic [G_W-1:0] gofs;
  mon_t           mon_nxt;
  day_t           day_nxt;
  year_t          year_nxt;

  always_comb begin
    midx = '0;
    gofs = s5_g_r;
    for (int k = 1; k < 12; k++) begin
      if (s5_g_r >= month_start(4'(k))) begin
        midx = 4'(k);
        gofs = s5_g_r - month_start(4'(k));
      end
    end
    day_nxt  = DAY_W'(gofs) + 5'd1;
    // January and February belong to the next calendar year.
    mon_nxt  = (midx < 4'd10) ? midx + 4'd3 : midx - 4'd9;
    year_nxt = YEAR_W'(s5_y_r) - YEAR_W'(RICH_Y) + YEAR_W'(midx >= 4'd10);
  end

  // Afternoon carry: a fraction of one half or more is on the next civil day.
  day_t          dim;
  logic [DAY_W:0] day_inc;
  year_t         o_year_nxt;
  mon_t          o_mon_nxt;
  day_t          o_day_nxt;

  always_comb begin
    dim        = month_len(s7_mon_r, s7_leap_r);
    day_inc    = {1'b0, s7_day_r} + 6'd1;
    o_year_nxt = s7_year_r;
    o_mon_nxt  = s7_mon_r;
    o_day_nxt  = s7_day_r;
    if (pm_r[NSTG-1]) begin
      if (day_inc > {1'b0, dim}) begin
        o_day_nxt = 5'd1;
        if (s7_mon_r == 4'd12) begin
          o_mon_nxt  = 4'd1;
          o_year_nxt = s7_year_r + 14'd1;
        end else begin
          o_mon_nxt = s7_mon_r + 4'd1;
        end
      end else begin
        o_day_nxt = day_inc[DAY_W-1:0];
      end
    end
  end

  // Output register.
  year_t o_year_r;
  mon_t  o_mon_r;
  day_t  o_day_r;
  tod_t  o_tod_r;

  always_ff @(posedge clk) begin
    // Stage 1: capture, 4*jd + 274277, hours.
    if (ld[1]) begin
      s1_dn_r           <= in_dn;
      s1_a_r            <= A_W'({in_dn, 2'b00}) + A_W'(RICH_B);
      tod_r[1]          <= '{hour: p24[FR_W+HOUR_W-1:FR_W], minute: '0,
                             second: '0, millisecond: '0};
      rem_r[1]          <= p24[FR_W-1:0];
      pm_r[1]           <= in_fr[FR_W-1];
    end
    // Stage 2: century term, minutes.
    if (ld[2]) begin
      s2_dn_r           <= s1_dn_r;
      s2_q1_r           <= Q1_W'(q1_prod >> Q1_SH);
      tod_r[2]          <= '{hour: tod_r[1].hour, minute: p60_m[FR_W+MIN_W-1:FR_W],
                             second: '0, millisecond: '0};
      rem_r[2]          <= p60_m[FR_W-1:0];
      pm_r[2]           <= pm_r[1];
    end
    // Stage 3: e = 4f + 3, seconds.
    if (ld[3]) begin
      s3_e_r            <= {f_val, 2'b11};
      tod_r[3]          <= '{hour: tod_r[2].hour, minute: tod_r[2].minute,
                             second: p60_s[FR_W+SEC_W-1:FR_W], millisecond: '0};
      rem_r[3]          <= p60_s[FR_W-1:0];
      pm_r[3]           <= pm_r[2];
    end
    // Stage 4: four-year cycle count e / 1461, milliseconds.
    if (ld[4]) begin
      s4_e_r                 <= s3_e_r;
      s4_y_r                 <= Y_W'(y_prod >> Y_SH);
      tod_r[4]               <= '{hour: tod_r[3].hour, minute: tod_r[3].minute,
                                  second: tod_r[3].second,
                                  millisecond: p1000[FR_W+MS_W-1:FR_W]};
      pm_r[4]                <= pm_r[3];
    end
    // Stage 5: day within the March-based year.
    if (ld[5]) begin
      s5_g_r            <= e_rem[G_W+1:2];
      s5_y_r            <= s4_y_r;
      s5_yy_r           <= s4_y_r + Y_W'(YY_OFS);
      tod_r[5]          <= tod_r[4];
      pm_r[5]           <= pm_r[4];
    end
    // Stage 6: month, day and year; century of the leap test.
    if (ld[6]) begin
      s6_year_r         <= year_nxt;
      s6_mon_r          <= mon_nxt;
      s6_day_r          <= day_nxt;
      s6_yy_r           <= s5_yy_r;
      s6_c_r            <= C_W'(c_prod >> C_SH);
      tod_r[6]          <= tod_r[5];
      pm_r[6]           <= pm_r[5];
    end
    // Stage 7: leap year flag.
    if (ld[7]) begin
      s7_year_r         <= s6_year_r;
      s7_mon_r          <= s6_mon_r;
      s7_day_r          <= s6_day_r;
      s7_leap_r         <= leap_nxt;
      tod_r[7]          <= tod_r[6];
      pm_r[7]           <= pm_r[6];
    end
    // Stage 8: afternoon carry into day, month and year.
    if (ld[8]) begin
      o_year_r          <= o_year_nxt;
      o_mon_r           <= o_mon_nxt;
      o_day_r           <= o_day_nxt;
      o_tod_r           <= tod_r[7];
    end
  end

  assign out_tvalid = v_r[NSTG];
  assign out_tdata  = {6'b000000, o_tod_r.millisecond, o_tod_r.second, o_tod_r.minute,
                       o_tod_r.hour, o_day_r, o_mon_r, o_year_r};

endmodule

`default_nettype wire

// ----- src/jdc_checker.sv -----
// Port-level checker for julian_day_to_calendar, attached by the bind below.
// Depends on jdc_pkg for the payload width.
`default_nettype none

module jdc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [jdc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import jdc_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // The input side is held off only when the whole pipeline is full and stalled.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input held off with room in the pipeline");

  // Every delivered result has a month from 1 to 12, a nonzero day and an hour of at most 23.
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[17:14] != 4'd0) && (out_tdata[17:14] <= 4'd12) &&
                   (out_tdata[22:18] != 5'd0) && (out_tdata[27:23] <= 5'd23))
    else $error("result date or hour out of range");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind julian_day_to_calendar jdc_checker u_jdc_checker (.*);

`default_nettype wire

// ----- tb/julian_day_to_calendar_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for julian_day_to_calendar: directed calendar edge cases,
// then random Julian dates under several idling phases. Depends on jdc_pkg and the RTL.

module julian_day_to_calendar_tb;
  import jdc_pkg::*;

  localparam int unsigned MAX_DAY_NUMBER = 4194303;
  localparam int unsigned RANDOM_PER_PHASE = 250;
  localparam int unsigned DRAIN_CYCLES = 16;

  // One decoded calendar result, in the same field order as out_tdata.
  typedef struct packed {
    logic [MS_W-1:0]   millisecond;
    logic [SEC_W-1:0]  second;
    logic [MIN_W-1:0]  minute;
    logic [HOUR_W-1:0] hour;
    day_t              day_of_month;
    mon_t              month;
    year_t             year;
  } cal_rec_t;

  // The scoreboard keeps its own calendar arithmetic and a queue of the dates that
  // accepted input transfers should produce, oldest first.
  class calendar_scoreboard;
    cal_rec_t pending_dates[$];
    int errors;
    int conversions;
    int results_seen;
    int month_carries;
    int year_carries;

    function int pending();
      return pending_dates.size();
    endfunction

    function bit is_leap_year(int year);
      int yy;
      yy = year + 4800;
      return ((yy % 4) == 0 && (yy % 100) != 0) || (yy % 400) == 0;
    endfunction

    function int unsigned days_in_month(int unsigned mon, int year);
      case (mon)
        2:            return is_leap_year(year) ? 29 : 28;
        4, 6, 9, 11:  return 30;
        default:      return 31;
      endcase
    endfunction

    // Richards' integer algorithm: the civil date at noon of the given day number.
    function void civil_date(input logic [21:0] dn, output int year,
                             output int unsigned mon, output int unsigned dom);
      longint unsigned jd, f, e, g, h;
      jd = 64'(dn);
      f = jd + 1401 + (((4 * jd + 274277) / 146097) * 3) / 4 - 38;
      e = 4 * f + 3;
      g = (e % 1461) / 4;
      h = 5 * g + 2;
      dom = int'((h % 153) / 5 + 1);
      mon = int'(((h / 153 + 2) % 12) + 1);
      year = int'(e / 1461) - 4716 + int'((14 - mon) / 12);
    endfunction

    function cal_rec_t predict_calendar(logic [21:0] dn, logic [31:0] fr);
      cal_rec_t r;
      int year;
      int unsigned mon, dom;
      logic [31:0] since_midnight;
      logic [63:0] p;
      civil_date(dn, year, mon, dom);
      // A Julian day starts at noon, so the afternoon half belongs to the next date.
      if (fr[31]) begin
        dom++;
        if (dom > days_in_month(mon, year)) begin
          dom = 1;
          mon++;
          month_carries++;
          if (mon > 12) begin
            mon = 1;
            year++;
            year_carries++;
          end
        end
      end
      // Exact fixed-point split of the time since midnight.
      since_midnight = fr + 32'h8000_0000;
      p = 64'(since_midnight) * 64'd24;
      r.hour = p[36:32];
      p = {32'd0, p[31:0]} * 64'd60;
      r.minute = p[37:32];
      p = {32'd0, p[31:0]} * 64'd60;
      r.second = p[37:32];
      p = {32'd0, p[31:0]} * 64'd1000;
      r.millisecond = p[41:32];
      r.year = year_t'(year);
      r.month = mon_t'(mon);
      r.day_of_month = day_t'(dom);
      return r;
    endfunction

    function void note_input(logic [21:0] dn, logic [31:0] fr);
      pending_dates.push_back(predict_calendar(dn, fr));
      conversions++;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_field(string name, logic [13:0] got, logic [13:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                  results_seen, name, got, want));
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] tdata);
      cal_rec_t got, want;
      got = cal_rec_t'(tdata[$bits(cal_rec_t)-1:0]);
      if (pending_dates.size() == 0) begin
        report_mismatch($sformatf("result 0x%h arrived with no conversion pending", tdata));
      end else begin
        want = pending_dates.pop_front();
        check_field("year", got.year, want.year);
        check_field("month", 14'(got.month), 14'(want.month));
        check_field("day_of_month", 14'(got.day_of_month), 14'(want.day_of_month));
        check_field("hour", 14'(got.hour), 14'(want.hour));
        check_field("minute", 14'(got.minute), 14'(want.minute));
        check_field("second", 14'(got.second), 14'(want.second));
        check_field("millisecond", 14'(got.millisecond), 14'(want.millisecond));
      end
      results_seen++;
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Receiver behavior, set by the stimulus process and acted on by the receiver.
  int out_stall_pct = 0;
  int hold_off_cycles = 0;

  calendar_scoreboard sb = new();

  julian_day_to_calendar dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver either sits out a long hold-off, counted down here, or stalls at
  // random with the probability of the current phase.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      out_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Every result transfer is checked against the oldest pending conversion.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata);
  end

  // Offers one Julian date after a random idle gap and returns once the transfer
  // has happened. The valid stays high for a following item unless an idle gap is drawn.
  task automatic send_date(logic [21:0] dn, logic [31:0] fr, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, fr, dn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(dn, fr);
  endtask

  // Lets the pipeline run dry with the sender silent.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Walks forward from a day number to the last day of a month, or of a year when
  // asked, so that afternoon fractions exercise the month and year carries.
  function automatic logic [21:0] month_end_from(logic [21:0] start, bit year_end);
    logic [21:0] dn;
    int year;
    int unsigned mon, dom;
    dn = (start > MAX_DAY_NUMBER - 400) ? 22'(MAX_DAY_NUMBER - 400) : start;
    for (int i = 0; i < 400; i++) begin
      sb.civil_date(dn, year, mon, dom);
      if (dom == sb.days_in_month(mon, year) && (!year_end || mon == 12))
        return dn;
      dn++;
    end
    return dn;
  endfunction

  function automatic logic [21:0] random_day_number();
    case ($urandom_range(5))
      0:       return 22'($urandom_range(0, MAX_DAY_NUMBER));
      1:       return 22'($urandom_range(2415000, 2500000));
      2:       return 22'($urandom_range(0, 2000));
      3:       return 22'($urandom_range(MAX_DAY_NUMBER - 5000, MAX_DAY_NUMBER));
      4:       return month_end_from(22'($urandom_range(0, MAX_DAY_NUMBER)), 1'b0);
      default: return month_end_from(22'($urandom_range(0, MAX_DAY_NUMBER)), 1'b1);
    endcase
  endfunction

  function automatic logic [31:0] random_fraction();
    case ($urandom_range(7))
      // Values right around noon and midnight, where the date and the hour turn over.
      0:       return 32'h8000_0000 + 32'($urandom_range(0, 7)) - 32'd4;
      1:       return 32'($urandom_range(0, 7)) - 32'd4;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    static logic [21:0] dir_dn [20] = '{
      22'd0, 22'd0, 22'd0, 22'd0,
      22'd37,        // last day of the first year, afternoon rolls into year -4712
      22'd96,        // February 28 of a negative leap year
      22'd97,        // February 29 of that year rolls into March
      22'd2451544,   // December 31, 1999 into the new year
      22'd2451545,
      22'd2451603,   // February 28 of a year divisible by 400
      22'd2451604,
      22'd2415079,   // February 28, 1900: a century year that is not leap
      22'd2488128,   // February 28, 2100: likewise
      22'd4194303, 22'd4194303, 22'd4194303,
      22'd2796202, 22'd1398101,
      22'd2460000, 22'd2451574
    };
    static logic [31:0] dir_fr [20] = '{
      32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
      32'h8000_0000, 32'hC000_0000, 32'h8000_0001, 32'h8000_0000,
      32'h0000_0000, 32'h9000_0000, 32'hA000_0000, 32'h8000_0000,
      32'hBFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h4000_0000, 32'hFFFF_FFFE
    };
    static int sender_idle [4] = '{0, 59, 0, 38};
    static int receiver_stall [4] = '{0, 0, 59, 38};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed dates with no idling on either side.
    for (int i = 0; i < 20; i++)
      send_date(dir_dn[i], dir_fr[i], 0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      out_stall_pct <= receiver_stall[ph];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Early in the first phase the receiver holds off long enough for the
        // pipeline to fill and push back on the sender, which keeps offering.
        if (ph == 0 && n == 20)
          hold_off_cycles <= 200;
        send_date(random_day_number(), random_fraction(), sender_idle[ph]);
      end
      // The sender pauses here until every pending result has come back.
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    while (sb.pending() > 0) begin
      void'(sb.pending_dates.pop_front());
      sb.report_mismatch("conversion still pending at the end of the run");
    end

    $display("Covered %0d conversions and %0d results over four idling phases,",
             sb.conversions, sb.results_seen);
    $display("with %0d month and %0d year carries from afternoon fractions.",
             sb.month_carries, sb.year_carries);
    if (sb.errors == 0) begin
      $display("PASS julian_day_to_calendar");
    end else begin
      $display("FAIL julian_day_to_calendar");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run needs.
  initial begin
    #3_000_000;
    $display("FAIL julian_day_to_calendar");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/jdc_pkg.sv
src/julian_day_to_calendar.sv
src/jdc_checker.sv
tb/julian_day_to_calendar_tb.sv
